// ===== rtl/xml_tag_tokenizer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// XML tag tokenizer assertion macros
// Shared property forms for the tokenizer checks.
// ----------------------------------------------------------------------------
`ifndef XML_TAG_TOKENIZER_UNIT_DEFINES_SVH
`define XML_TAG_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define XTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xtt check failed");

// next-cycle implication, disabled during reset
`define XTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xtt check failed");

`endif

// ===== rtl/xtt_pkg.sv =====
// ----------------------------------------------------------------------------
// XML tag tokenizer package
// Parse phases, result codes and character constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xtt_pkg;

  localparam int CharW = 8;
  localparam int KindW = 3;
  localparam int TypeW = 2;
  localparam int ErrW  = 3;

  typedef enum logic [10:0] {
    PH_SEEK        = 11'b000_0000_0001,
    PH_AFTER_LT    = 11'b000_0000_0010,
    PH_TITLE_START = 11'b000_0000_0100,
    PH_TITLE       = 11'b000_0000_1000,
    PH_GAP         = 11'b000_0001_0000,
    PH_NAME        = 11'b000_0010_0000,
    PH_EQ          = 11'b000_0100_0000,
    PH_VALUE       = 11'b000_1000_0000,
    PH_VALUE_ESC   = 11'b001_0000_0000,
    PH_SLASH       = 11'b010_0000_0000,
    PH_DISCARD     = 11'b100_0000_0000
  } phase_t;

  localparam logic [KindW-1:0] KIND_OUTSIDE = 3'd0;
  localparam logic [KindW-1:0] KIND_MARKUP  = 3'd1;
  localparam logic [KindW-1:0] KIND_TITLE   = 3'd2;
  localparam logic [KindW-1:0] KIND_NAME    = 3'd3;
  localparam logic [KindW-1:0] KIND_VALUE   = 3'd4;
  localparam logic [KindW-1:0] KIND_DISCARD = 3'd5;

  localparam logic [TypeW-1:0] TAG_BEGIN  = 2'd0;
  localparam logic [TypeW-1:0] TAG_END    = 2'd1;
  localparam logic [TypeW-1:0] TAG_SINGLE = 2'd2;

  localparam logic [ErrW-1:0] ERR_NONE     = 3'd0;
  localparam logic [ErrW-1:0] ERR_NO_TITLE = 3'd1;
  localparam logic [ErrW-1:0] ERR_NO_EQ    = 3'd2;
  localparam logic [ErrW-1:0] ERR_NO_QUOTE = 3'd3;
  localparam logic [ErrW-1:0] ERR_DBL_SL   = 3'd4;
  localparam logic [ErrW-1:0] ERR_NO_GT    = 3'd5;

  localparam logic [CharW-1:0] CH_LT    = 8'h3C;
  localparam logic [CharW-1:0] CH_GT    = 8'h3E;
  localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
  localparam logic [CharW-1:0] CH_EQ    = 8'h3D;
  localparam logic [CharW-1:0] CH_BSL   = 8'h5C;
  localparam logic [CharW-1:0] CH_QUOTE = 8'h22;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_NL    = 8'h0A;
  localparam logic [CharW-1:0] CH_UNDER = 8'h5F;

  function automatic logic is_word(input logic [CharW-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == CH_SPACE) || (c == CH_NL);
  endfunction

endpackage

// ===== rtl/xml_tag_tokenizer_unit.sv =====
// One byte enters per transfer and one classified result leaves for it, in order.
// Sustained rate is one byte per clock while the result side does not stall; a byte
// passes through the input register, then the result register, with the tag-parser
// next-state logic between them. Stalls on the result side hold the result
// register and back up through the input register.
// ----------------------------------------------------------------------------
// XML tag tokenizer unit
// Per-byte classifier for XML-like tags with attribute and error flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xml_tag_tokenizer_unit_defines.svh"

module xml_tag_tokenizer_unit
  import xtt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CharW-1:0] in_char_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CharW-1:0] out_char_out,
  output logic [KindW-1:0] out_char_kind,
  output logic             out_attr_done,
  output logic             out_attr_has_value,
  output logic             out_tag_done,
  output logic [TypeW-1:0] out_tag_type,
  output logic [ErrW-1:0]  out_error_code
);

  logic             s1_valid_r;
  logic [CharW-1:0] s1_char_r;
  logic             adv;
  logic             step;

  phase_t phase_r, phase_nxt;
  logic   end_seen_r, end_seen_nxt;
  logic   dq_r, dq_nxt;
  logic   esc_r, esc_nxt;

  logic             out_valid_r;
  logic [CharW-1:0] char_r;
  logic [KindW-1:0] kind_r, kind_nxt;
  logic             adone_r, adone_nxt;
  logic             ahas_r, ahas_nxt;
  logic             tdone_r, tdone_nxt;
  logic [TypeW-1:0] ttype_r, ttype_nxt;
  logic [ErrW-1:0]  err_r, err_nxt;

  logic             do_tend;
  logic             do_fail;
  logic [ErrW-1:0]  fail_code;
  logic [CharW-1:0] c;

  assign adv      = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign c        = s1_char_r;

  always_comb begin
    phase_nxt    = phase_r;
    end_seen_nxt = end_seen_r;
    dq_nxt       = dq_r;
    esc_nxt      = esc_r;
    kind_nxt     = KIND_OUTSIDE;
    adone_nxt    = 1'b0;
    ahas_nxt     = 1'b0;
    tdone_nxt    = 1'b0;
    ttype_nxt    = TAG_BEGIN;
    err_nxt      = ERR_NONE;
    do_tend      = 1'b0;
    do_fail      = 1'b0;
    fail_code    = ERR_NONE;

    case (phase_r)
      PH_AFTER_LT: begin
        if (c == CH_SLASH) begin
          kind_nxt     = KIND_MARKUP;
          end_seen_nxt = 1'b1;
          phase_nxt    = PH_TITLE_START;
        end else if (is_word(c)) begin
          kind_nxt  = KIND_TITLE;
          phase_nxt = PH_TITLE;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_NO_TITLE;
        end
      end
      PH_TITLE_START: begin
        if (is_word(c)) begin
          kind_nxt  = KIND_TITLE;
          phase_nxt = PH_TITLE;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_NO_TITLE;
        end
      end
      PH_TITLE: begin
        if (is_word(c)) begin
          kind_nxt = KIND_TITLE;
        end else if (is_space(c)) begin
          kind_nxt  = KIND_MARKUP;
          phase_nxt = PH_GAP;
        end else begin
          do_tend = 1'b1;
        end
      end
      PH_GAP: begin
        if (is_space(c)) begin
          kind_nxt = KIND_MARKUP;
        end else if (is_word(c)) begin
          kind_nxt  = KIND_NAME;
          phase_nxt = PH_NAME;
        end else begin
          do_tend = 1'b1;
        end
      end
      PH_NAME: begin
        if (is_word(c)) begin
          kind_nxt = KIND_NAME;
        end else if (is_space(c)) begin
          kind_nxt  = KIND_MARKUP;
          adone_nxt = 1'b1;
          phase_nxt = PH_GAP;
        end else if (c == CH_SLASH || c == CH_GT) begin
          adone_nxt = 1'b1;
          do_tend   = 1'b1;
        end else if (c == CH_EQ) begin
          kind_nxt  = KIND_MARKUP;
          phase_nxt = PH_EQ;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_NO_EQ;
        end
      end
      PH_EQ: begin
        if (c == CH_QUOTE) begin
          kind_nxt  = KIND_MARKUP;
          phase_nxt = PH_VALUE;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_NO_QUOTE;
        end
      end
      PH_VALUE: begin
        if (c == CH_BSL) begin
          kind_nxt  = KIND_VALUE;
          phase_nxt = PH_VALUE_ESC;
        end else if (c == CH_QUOTE) begin
          kind_nxt  = KIND_MARKUP;
          adone_nxt = 1'b1;
          ahas_nxt  = 1'b1;
          phase_nxt = PH_GAP;
        end else begin
          kind_nxt = KIND_VALUE;
        end
      end
      PH_VALUE_ESC: begin
        kind_nxt  = KIND_VALUE;
        phase_nxt = PH_VALUE;
      end
      PH_SLASH: begin
        if (c == CH_GT) begin
          kind_nxt     = KIND_MARKUP;
          tdone_nxt    = 1'b1;
          ttype_nxt    = TAG_SINGLE;
          phase_nxt    = PH_SEEK;
          end_seen_nxt = 1'b0;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_NO_GT;
        end
      end
      PH_DISCARD: begin
        kind_nxt = KIND_DISCARD;
        if (dq_r) begin
          if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (c == CH_BSL) begin
            esc_nxt = 1'b1;
          end else if (c == CH_QUOTE) begin
            dq_nxt = 1'b0;
          end
        end else if (c == CH_QUOTE) begin
          dq_nxt  = 1'b1;
          esc_nxt = 1'b0;
        end else if (c == CH_GT) begin
          phase_nxt    = PH_SEEK;
          end_seen_nxt = 1'b0;
        end
      end
      default: begin
        end_seen_nxt = 1'b0;
        if (c == CH_LT) begin
          kind_nxt  = KIND_MARKUP;
          phase_nxt = PH_AFTER_LT;
        end else begin
          kind_nxt  = KIND_OUTSIDE;
          phase_nxt = PH_SEEK;
        end
      end
    endcase

    // only '/' or '>' may close here
    if (do_tend) begin
      if (c == CH_SLASH) begin
        if (end_seen_r) begin
          do_fail   = 1'b1;
          fail_code = ERR_DBL_SL;
        end else begin
          kind_nxt  = KIND_MARKUP;
          phase_nxt = PH_SLASH;
        end
      end else if (c == CH_GT) begin
        kind_nxt     = KIND_MARKUP;
        tdone_nxt    = 1'b1;
        ttype_nxt    = end_seen_r ? TAG_END : TAG_BEGIN;
        phase_nxt    = PH_SEEK;
        end_seen_nxt = 1'b0;
      end else begin
        do_fail   = 1'b1;
        fail_code = ERR_NO_GT;
      end
    end

    if (do_fail) begin
      kind_nxt = KIND_DISCARD;
      err_nxt  = fail_code;
      esc_nxt  = 1'b0;
      if (c == CH_GT) begin
        dq_nxt       = 1'b0;
        phase_nxt    = PH_SEEK;
        end_seen_nxt = 1'b0;
      end else begin
        dq_nxt    = (c == CH_QUOTE);
        phase_nxt = PH_DISCARD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SEEK;
      end_seen_r  <= 1'b0;
      dq_r        <= 1'b0;
      esc_r       <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (step) begin
        phase_r    <= phase_nxt;
        end_seen_r <= end_seen_nxt;
        dq_r       <= dq_nxt;
        esc_r      <= esc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_char_r <= in_char_in;
    end
    if (step) begin
      char_r  <= s1_char_r;
      kind_r  <= kind_nxt;
      adone_r <= adone_nxt;
      ahas_r  <= ahas_nxt;
      tdone_r <= tdone_nxt;
      ttype_r <= ttype_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_char_out       = char_r;
  assign out_char_kind      = kind_r;
  assign out_attr_done      = adone_r;
  assign out_attr_has_value = ahas_r;
  assign out_tag_done       = tdone_r;
  assign out_tag_type       = ttype_r;
  assign out_error_code     = err_r;

  `XTT_ASSERT_NOW(a_tag_done_clean, clk, rst_n, out_valid_r && tdone_r, err_r == ERR_NONE && kind_r == KIND_MARKUP)
  `XTT_ASSERT_NOW(a_err_discard, clk, rst_n, out_valid_r && err_r != ERR_NONE, kind_r == KIND_DISCARD)
  `XTT_ASSERT_NOW(a_has_value_done, clk, rst_n, out_valid_r && ahas_r, adone_r && kind_r == KIND_MARKUP)
  `XTT_ASSERT_NOW(a_esc_in_quotes, clk, rst_n, esc_r, phase_r == PH_DISCARD && dq_r)
  `XTT_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !adv, s1_valid_r && $stable(s1_char_r))

endmodule

// ===== dv/tb_xml_tag_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// XML tag tokenizer unit testbench
// Streams directed and random tag text through the tokenizer with random
// idling on both sides and checks every classified byte against a local
// parser model or, for some directed bytes, a fixed expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_xml_tag_tokenizer_unit;
  import xtt_pkg::*;

  localparam int          RANDOM_BYTES = 1500;
  localparam int          HOLD_AFTER   = 200;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int          SIDE_TX      = 0;
  localparam int          SIDE_RX      = 1;
  localparam int          MAX_REPORTS  = 50;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic [KindW-1:0] kind;
    logic             adone;
    logic             ahas;
    logic             tdone;
    logic [TypeW-1:0] ttype;
    logic [ErrW-1:0]  err;
  } tok_res_t;

  typedef struct packed {
    logic     typed;
    tok_res_t res;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CharW-1:0] in_char_in = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CharW-1:0] out_char_out;
  logic [KindW-1:0] out_char_kind;
  logic             out_attr_done;
  logic             out_attr_has_value;
  logic             out_tag_done;
  logic [TypeW-1:0] out_tag_type;
  logic [ErrW-1:0]  out_error_code;

  row_t        stim_q[$];
  tok_res_t    pending_tokens[$];
  int          err_count = 0;
  int          tokens_seen = 0;
  int unsigned cycle_count = 0;
  int          burst_left[2] = '{0, 0};
  bit          tag_broken;

  phase_t tok_phase;
  logic   closing_tag;
  logic   skip_quoted;
  logic   skip_escaped;

  xml_tag_tokenizer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_in         (in_char_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_char_out       (out_char_out),
    .out_char_kind      (out_char_kind),
    .out_attr_done      (out_attr_done),
    .out_attr_has_value (out_attr_has_value),
    .out_tag_done       (out_tag_done),
    .out_tag_type       (out_tag_type),
    .out_error_code     (out_error_code)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("xml_tag_tokenizer_unit test failed");
      $finish;
    end
  end

  function automatic logic word_ch(input logic [CharW-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
  endfunction

  function automatic logic blank_ch(input logic [CharW-1:0] c);
    return (c == CH_SPACE) || (c == CH_NL);
  endfunction

  // Classifies one byte and advances the parser state.
  function automatic tok_res_t tokenise(input logic [CharW-1:0] c);
    tok_res_t        r;
    logic [ErrW-1:0] fault;
    logic            at_tag_end;
    r = '0;
    r.ch = c;
    fault = ERR_NONE;
    at_tag_end = 1'b0;
    case (tok_phase)
      PH_AFTER_LT: begin
        if (c == CH_SLASH) begin
          r.kind = KIND_MARKUP;
          closing_tag = 1'b1;
          tok_phase = PH_TITLE_START;
        end else if (word_ch(c)) begin
          r.kind = KIND_TITLE;
          tok_phase = PH_TITLE;
        end else begin
          fault = ERR_NO_TITLE;
        end
      end
      PH_TITLE_START: begin
        if (word_ch(c)) begin
          r.kind = KIND_TITLE;
          tok_phase = PH_TITLE;
        end else begin
          fault = ERR_NO_TITLE;
        end
      end
      PH_TITLE: begin
        if (word_ch(c)) begin
          r.kind = KIND_TITLE;
        end else if (blank_ch(c)) begin
          r.kind = KIND_MARKUP;
          tok_phase = PH_GAP;
        end else begin
          at_tag_end = 1'b1;
        end
      end
      PH_GAP: begin
        if (blank_ch(c)) begin
          r.kind = KIND_MARKUP;
        end else if (word_ch(c)) begin
          r.kind = KIND_NAME;
          tok_phase = PH_NAME;
        end else begin
          at_tag_end = 1'b1;
        end
      end
      PH_NAME: begin
        if (word_ch(c)) begin
          r.kind = KIND_NAME;
        end else if (blank_ch(c)) begin
          r.kind = KIND_MARKUP;
          r.adone = 1'b1;
          tok_phase = PH_GAP;
        end else if (c == CH_SLASH || c == CH_GT) begin
          r.adone = 1'b1;
          at_tag_end = 1'b1;
        end else if (c == CH_EQ) begin
          r.kind = KIND_MARKUP;
          tok_phase = PH_EQ;
        end else begin
          fault = ERR_NO_EQ;
        end
      end
      PH_EQ: begin
        if (c == CH_QUOTE) begin
          r.kind = KIND_MARKUP;
          tok_phase = PH_VALUE;
        end else begin
          fault = ERR_NO_QUOTE;
        end
      end
      PH_VALUE: begin
        if (c == CH_BSL) begin
          r.kind = KIND_VALUE;
          tok_phase = PH_VALUE_ESC;
        end else if (c == CH_QUOTE) begin
          r.kind = KIND_MARKUP;
          r.adone = 1'b1;
          r.ahas = 1'b1;
          tok_phase = PH_GAP;
        end else begin
          r.kind = KIND_VALUE;
        end
      end
      PH_VALUE_ESC: begin
        r.kind = KIND_VALUE;
        tok_phase = PH_VALUE;
      end
      PH_SLASH: begin
        if (c == CH_GT) begin
          r.kind = KIND_MARKUP;
          r.tdone = 1'b1;
          r.ttype = TAG_SINGLE;
          tok_phase = PH_SEEK;
          closing_tag = 1'b0;
        end else begin
          fault = ERR_NO_GT;
        end
      end
      PH_DISCARD: begin
        r.kind = KIND_DISCARD;
        if (skip_quoted) begin
          if (skip_escaped) begin
            skip_escaped = 1'b0;
          end else if (c == CH_BSL) begin
            skip_escaped = 1'b1;
          end else if (c == CH_QUOTE) begin
            skip_quoted = 1'b0;
          end
        end else if (c == CH_QUOTE) begin
          skip_quoted = 1'b1;
          skip_escaped = 1'b0;
        end else if (c == CH_GT) begin
          tok_phase = PH_SEEK;
          closing_tag = 1'b0;
        end
      end
      default: begin
        closing_tag = 1'b0;
        if (c == CH_LT) begin
          r.kind = KIND_MARKUP;
          tok_phase = PH_AFTER_LT;
        end else begin
          r.kind = KIND_OUTSIDE;
          tok_phase = PH_SEEK;
        end
      end
    endcase
    // only '/' or '>' may follow here
    if (at_tag_end) begin
      if (c == CH_SLASH) begin
        if (closing_tag) begin
          fault = ERR_DBL_SL;
        end else begin
          r.kind = KIND_MARKUP;
          tok_phase = PH_SLASH;
        end
      end else if (c == CH_GT) begin
        r.kind = KIND_MARKUP;
        r.tdone = 1'b1;
        r.ttype = closing_tag ? TAG_END : TAG_BEGIN;
        tok_phase = PH_SEEK;
        closing_tag = 1'b0;
      end else begin
        fault = ERR_NO_GT;
      end
    end
    if (fault != ERR_NONE) begin
      r.kind = KIND_DISCARD;
      r.err = fault;
      skip_escaped = 1'b0;
      if (c == CH_GT) begin
        tok_phase = PH_SEEK;
        closing_tag = 1'b0;
        skip_quoted = 1'b0;
      end else begin
        tok_phase = PH_DISCARD;
        skip_quoted = (c == CH_QUOTE);
      end
    end
    return r;
  endfunction

  function automatic row_t model_row(input logic [CharW-1:0] c);
    row_t row;
    row = '0;
    row.res.ch = c;
    return row;
  endfunction

  function automatic row_t typed_row(input logic [CharW-1:0] c, input logic [KindW-1:0] k,
                                     input logic ad, input logic ah, input logic td,
                                     input logic [TypeW-1:0] tt, input logic [ErrW-1:0] e);
    row_t row;
    row.typed = 1'b1;
    row.res = '{ch: c, kind: k, adone: ad, ahas: ah, tdone: td, ttype: tt, err: e};
    return row;
  endfunction

  function automatic void put(input logic [CharW-1:0] c);
    stim_q.push_back(model_row(c));
  endfunction

  function automatic void emit(input logic [CharW-1:0] c);
    if (!tag_broken) put(c);
  endfunction

  function automatic void chance_break();
    logic [CharW-1:0] b;
    if (!tag_broken && $urandom_range(0, 14) == 0) begin
      case ($urandom_range(0, 8))
        0: b = CH_LT;
        1: b = CH_GT;
        2: b = CH_SLASH;
        3: b = CH_EQ;
        4: b = CH_QUOTE;
        5: b = CH_BSL;
        6: b = CH_SPACE;
        7: b = CH_NL;
        default: b = CharW'($urandom_range(0, 255));
      endcase
      put(b);
      tag_broken = 1'b1;
    end
  endfunction

  function automatic logic [CharW-1:0] word_byte();
    int k;
    k = $urandom_range(0, 62);
    if (k < 10) return 8'h30 + k[7:0];
    if (k < 36) return 8'h41 + k[7:0] - 8'd10;
    if (k < 62) return 8'h61 + k[7:0] - 8'd36;
    return CH_UNDER;
  endfunction

  // Mostly well-formed tags with random content, some broken, some noise.
  function automatic void gen_tag();
    logic [CharW-1:0] b;
    bit               is_end;
    tag_broken = 1'b0;
    repeat ($urandom_range(0, 3)) begin
      b = CharW'($urandom_range(0, 255));
      put((b == CH_LT) ? ~CH_LT : b);
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) put(CharW'($urandom_range(0, 255)));
    end
    put(CH_LT);
    is_end = ($urandom_range(0, 3) == 0);
    if (is_end) emit(CH_SLASH);
    chance_break();
    repeat ($urandom_range(1, 4)) emit(word_byte());
    chance_break();
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 2)) emit($urandom_range(0, 1) ? CH_SPACE : CH_NL);
      repeat ($urandom_range(1, 3)) emit(word_byte());
      chance_break();
      if ($urandom_range(0, 1)) begin
        emit(CH_EQ);
        chance_break();
        emit(CH_QUOTE);
        repeat ($urandom_range(0, 4)) begin
          b = CharW'($urandom_range(0, 255));
          if (b == CH_QUOTE || b == CH_BSL || $urandom_range(0, 7) == 0) emit(CH_BSL);
          emit(b);
        end
        emit(CH_QUOTE);
        chance_break();
      end
    end
    if ($urandom_range(0, 2) == 0) emit($urandom_range(0, 1) ? CH_SPACE : CH_NL);
    if (!is_end && $urandom_range(0, 2) == 0) emit(CH_SLASH);
    chance_break();
    put(CH_GT);
  endfunction

  // Random wait per transfer, with occasional bursts of back-to-back transfers.
  function automatic int draw_wait(input int side);
    if (burst_left[side] > 0) begin
      burst_left[side] = burst_left[side] - 1;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left[side] = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (err_count < MAX_REPORTS) $display("ERROR: %s", msg);
    err_count++;
  endtask

  task automatic check_token(input tok_res_t want, input tok_res_t got);
    string at;
    at = $sformatf("result %0d", tokens_seen);
    if (got.ch !== want.ch)
      flag_mismatch($sformatf("%s char_out exp %0h got %0h", at, want.ch, got.ch));
    if (got.kind !== want.kind)
      flag_mismatch($sformatf("%s char_kind exp %0d got %0d", at, want.kind, got.kind));
    if (got.adone !== want.adone)
      flag_mismatch($sformatf("%s attr_done exp %0d got %0d", at, want.adone, got.adone));
    if (got.ahas !== want.ahas)
      flag_mismatch($sformatf("%s attr_has_value exp %0d got %0d", at, want.ahas, got.ahas));
    if (got.tdone !== want.tdone)
      flag_mismatch($sformatf("%s tag_done exp %0d got %0d", at, want.tdone, got.tdone));
    if (got.ttype !== want.ttype)
      flag_mismatch($sformatf("%s tag_type exp %0d got %0d", at, want.ttype, got.ttype));
    if (got.err !== want.err)
      flag_mismatch($sformatf("%s error_code exp %0d got %0d", at, want.err, got.err));
  endtask

  // Result side: random stall per transfer, plus one long hold to back the block up.
  initial begin
    tok_res_t got;
    int       hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = (tokens_seen == HOLD_AFTER) ? HOLD_CYCLES : draw_wait(SIDE_RX);
      repeat (hold) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{ch: out_char_out, kind: out_char_kind, adone: out_attr_done,
              ahas: out_attr_has_value, tdone: out_tag_done, ttype: out_tag_type,
              err: out_error_code};
      if (pending_tokens.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer, char_out %0h", got.ch));
      end else begin
        check_token(pending_tokens.pop_front(), got);
      end
      tokens_seen++;
    end
  end

  initial begin
    row_t     row;
    tok_res_t want;
    int       n_dir;
    tok_phase = PH_SEEK;
    closing_tag = 1'b0;
    skip_quoted = 1'b0;
    skip_escaped = 1'b0;

    // byte extremes outside a tag, then '>' straight after '<'
    stim_q.push_back(typed_row(8'h00, KIND_OUTSIDE, 1'b0, 1'b0, 1'b0, TAG_BEGIN, ERR_NONE));
    stim_q.push_back(typed_row(8'hFF, KIND_OUTSIDE, 1'b0, 1'b0, 1'b0, TAG_BEGIN, ERR_NONE));
    stim_q.push_back(typed_row(CH_LT, KIND_MARKUP, 1'b0, 1'b0, 1'b0, TAG_BEGIN, ERR_NONE));
    stim_q.push_back(typed_row(CH_GT, KIND_DISCARD, 1'b0, 1'b0, 1'b0, TAG_BEGIN,
                               ERR_NO_TITLE));
    // end tag with valueless attribute and a second slash
    stim_q.push_back(model_row(CH_LT));
    stim_q.push_back(model_row(CH_SLASH));
    stim_q.push_back(model_row("a"));
    stim_q.push_back(model_row(CH_SPACE));
    stim_q.push_back(model_row("n"));
    stim_q.push_back(typed_row(CH_SLASH, KIND_DISCARD, 1'b1, 1'b0, 1'b0, TAG_BEGIN,
                               ERR_DBL_SL));
    // discard with quoted '>' and escaped quote
    stim_q.push_back(model_row(CH_QUOTE));
    stim_q.push_back(model_row(CH_BSL));
    stim_q.push_back(model_row(CH_QUOTE));
    stim_q.push_back(model_row(CH_GT));
    stim_q.push_back(model_row(CH_QUOTE));
    stim_q.push_back(model_row(CH_GT));
    // single tag with escaped value
    stim_q.push_back(model_row(CH_LT));
    stim_q.push_back(model_row("b"));
    stim_q.push_back(model_row(CH_NL));
    stim_q.push_back(model_row("k"));
    stim_q.push_back(model_row(CH_EQ));
    stim_q.push_back(model_row(CH_QUOTE));
    stim_q.push_back(model_row(CH_BSL));
    stim_q.push_back(model_row(CH_QUOTE));
    stim_q.push_back(model_row(CH_QUOTE));
    stim_q.push_back(model_row(CH_SLASH));
    stim_q.push_back(typed_row(CH_GT, KIND_MARKUP, 1'b0, 1'b0, 1'b1, TAG_SINGLE, ERR_NONE));
    // stray '<' inside a tag
    stim_q.push_back(model_row(CH_LT));
    stim_q.push_back(model_row("c"));
    stim_q.push_back(typed_row(CH_LT, KIND_DISCARD, 1'b0, 1'b0, 1'b0, TAG_BEGIN, ERR_NO_GT));
    stim_q.push_back(model_row(CH_GT));

    n_dir = stim_q.size();
    while (stim_q.size() < n_dir + RANDOM_BYTES) gen_tag();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_q[i]) begin
      row = stim_q[i];
      repeat (draw_wait(SIDE_TX)) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_char_in <= row.res.ch;
      do @(posedge clk); while (in_stall !== 1'b0);
      want = tokenise(row.res.ch);
      if (row.typed) want = row.res;
      pending_tokens.push_back(want);
    end
    in_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_tokens.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_tokens.size()));

    if (err_count == 0) begin
      $display("xml_tag_tokenizer_unit test passed");
    end else begin
      $display("xml_tag_tokenizer_unit test failed");
    end
    $finish;
  end

endmodule
